FILE: rtl/vdc_pkg.sv
// ----------------------------------------------------------------------------
// vdc_pkg
// Shared types and constants for the voice DC blocker, gain and soft limiter.
// ----------------------------------------------------------------------------
package vdc_pkg;

	localparam int FRAME_MAX = 512;
	localparam int POS_W = $clog2(FRAME_MAX + 1);

	localparam int SAMPLE_W = 16;
	localparam int HIST_W = 26;
	localparam int GAIN_W = 10;
	localparam int LEVEL_W = 15;
	localparam int LIMCNT_W = 10;

	localparam int SUM_W = 40;
	localparam int ROOT_W = SUM_W / 2;
	localparam int DEN_W = 19;
	localparam int STEP_W = $clog2(SUM_W + 1);
	localparam int SHORT_STEPS = 16;
	localparam int ROOT_CNT_W = $clog2(ROOT_W + 1);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 15;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KNEE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CEIL = 2'd2;

	localparam logic [GAIN_W-1:0] GAIN_RST = 10'd256;
	localparam logic [LEVEL_W-1:0] KNEE_RST = 15'd28672;
	localparam logic [LEVEL_W-1:0] CEIL_RST = 15'd32751;

	localparam logic [SUM_W-1:0] SUM_MAX = '1;
	localparam logic [LIMCNT_W-1:0] LIMCNT_MAX = '1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_in;
		logic frame_last;
		logic clear_history;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_sample;
		logic frame_end;
		logic [15:0] pre_limit_rms;
		logic [LEVEL_W-1:0] post_limit_rms;
		logic [LEVEL_W-1:0] post_limit_peak;
		logic [LIMCNT_W-1:0] limited_samples;
	} out_item_t;

	typedef struct packed {
		logic [GAIN_W-1:0] gain_q8;
		logic [LEVEL_W-1:0] limit_knee;
		logic [LEVEL_W-1:0] limit_ceiling;
	} cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] clamped;
		logic close;
		logic [POS_W-1:0] count;
	} q_entry_t;

	typedef struct packed {
		logic push;
		q_entry_t entry;
	} q_wr_t;

	typedef struct packed {
		logic valid;
		q_entry_t entry;
	} q_rd_t;

	typedef struct packed {
		logic start;
		logic long_mode;
		logic [SUM_W-1:0] dividend;
		logic [DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [SUM_W-1:0] quotient;
	} div_rsp_t;

endpackage

FILE: rtl/vdc_front.sv
// ----------------------------------------------------------------------------
// vdc_front
// Input side: DC blocker with history, 16-bit clamp and frame close detection.
// ----------------------------------------------------------------------------
module vdc_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input vdc_pkg::in_item_t in_item,
	input logic q_full,
	output vdc_pkg::q_wr_t q_wr
);
	import vdc_pkg::*;

	logic signed [SAMPLE_W-1:0] xp_q;
	logic signed [HIST_W-1:0] yp_q;
	logic [POS_W-1:0] pos_q;

	logic accept;
	logic signed [SAMPLE_W-1:0] xp;
	logic signed [HIST_W-1:0] yp;
	logic signed [HIST_W+7:0] yp_x255;
	logic signed [HIST_W-1:0] fb;
	logic signed [HIST_W+1:0] y_full;
	logic signed [HIST_W-1:0] y_sat;
	logic signed [SAMPLE_W-1:0] clamped;
	logic [POS_W-1:0] n;
	logic close;

	assign in_stall = q_full;
	assign accept = in_valid && !q_full;

	assign xp = in_item.clear_history ? '0 : xp_q;
	assign yp = in_item.clear_history ? '0 : yp_q;
	assign yp_x255 = ((HIST_W + 8)'(yp) <<< 8) - (HIST_W + 8)'(yp);
	assign fb = yp_x255[HIST_W+7:8];
	assign y_full = (HIST_W + 2)'(in_item.sample_in) - (HIST_W + 2)'(xp) + (HIST_W + 2)'(fb);

	always_comb begin
		if (y_full > 28'sd33554431) begin
			y_sat = 26'sd33554431;
		end else if (y_full < -28'sd33554432) begin
			y_sat = -26'sd33554432;
		end else begin
			y_sat = y_full[HIST_W-1:0];
		end
		if (y_sat > 26'sd32767) begin
			clamped = 16'sd32767;
		end else if (y_sat < -26'sd32768) begin
			clamped = -16'sd32768;
		end else begin
			clamped = y_sat[SAMPLE_W-1:0];
		end
	end

	assign n = pos_q + 1'b1;
	assign close = in_item.frame_last || (n >= POS_W'(FRAME_MAX));

	assign q_wr.push = accept;
	assign q_wr.entry.clamped = clamped;
	assign q_wr.entry.close = close;
	assign q_wr.entry.count = n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xp_q <= '0;
			yp_q <= '0;
			pos_q <= '0;
		end else if (accept) begin
			xp_q <= in_item.sample_in;
			yp_q <= y_sat;
			pos_q <= close ? '0 : n;
		end
	end

endmodule

FILE: rtl/vdc_queue.sv
// ----------------------------------------------------------------------------
// vdc_queue
// Short item queue between the filter front and the limiter back.
// ----------------------------------------------------------------------------
module vdc_queue (
	input logic clk,
	input logic arst_n,
	input vdc_pkg::q_wr_t wr,
	output logic full,
	output vdc_pkg::q_rd_t rd,
	input logic pop
);
	import vdc_pkg::*;

	q_entry_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	logic do_push;
	logic do_pop;

	assign full = (cnt_q == QCNT_W'(QDEPTH));
	assign rd.valid = (cnt_q != '0);
	assign rd.entry = mem_q[rd_ptr_q];
	assign do_push = wr.push && !full;
	assign do_pop = pop && rd.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/vdc_divider.sv
// ----------------------------------------------------------------------------
// vdc_divider
// Restoring divider, one quotient bit per cycle, short or full-width run.
// ----------------------------------------------------------------------------
module vdc_divider (
	input logic clk,
	input logic arst_n,
	input vdc_pkg::div_req_t req,
	output vdc_pkg::div_rsp_t rsp
);
	import vdc_pkg::*;

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [SUM_W-1:0] num_q;
	logic [STEP_W-1:0] cnt_q;
	logic done_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic fits;

	assign trial = {rem_q, num_q[SUM_W-1]};
	assign diff = trial - {1'b0, den_q};
	assign fits = (trial >= {1'b0, den_q});

	assign rsp.done = done_q;
	assign rsp.quotient = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !req.start && (cnt_q == STEP_W'(1));
			if (req.start) begin
				cnt_q <= req.long_mode ? STEP_W'(SUM_W) : STEP_W'(SHORT_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.divisor;
			if (req.long_mode) begin
				rem_q <= '0;
				num_q <= req.dividend;
			end else begin
				rem_q <= req.dividend[SHORT_STEPS +: DEN_W];
				num_q <= {req.dividend[SHORT_STEPS-1:0], {(SUM_W - SHORT_STEPS){1'b0}}};
			end
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			num_q <= {num_q[SUM_W-2:0], fits};
		end
	end

endmodule

FILE: rtl/vdc_back.sv
// ----------------------------------------------------------------------------
// vdc_back
// Gain, soft limiter, frame statistics, RMS by divide and square root, output.
// ----------------------------------------------------------------------------
module vdc_back (
	input logic clk,
	input logic arst_n,
	input vdc_pkg::cfg_t cfg,
	input vdc_pkg::q_rd_t rd,
	output logic pop,
	output vdc_pkg::div_req_t div_req,
	input vdc_pkg::div_rsp_t div_rsp,
	output logic out_valid,
	input logic out_stall,
	output vdc_pkg::out_item_t out_item
);
	import vdc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL, ST_LIM, ST_OVR, ST_LSTART, ST_DIVL, ST_CAP, ST_POST,
		ST_ACC, ST_PSTART, ST_DIVP, ST_SQP, ST_QSTART, ST_DIVQ, ST_SQQ, ST_EMIT
	} state_t;

	state_t state_q;
	logic signed [SAMPLE_W-1:0] clamped_q;
	logic close_q;
	logic [POS_W-1:0] count_q;
	logic signed [26:0] prod_q;
	logic [30:0] presq_q;
	logic neg_q;
	logic [17:0] mag_q;
	logic [17:0] over_q;
	logic [LEVEL_W-1:0] range_q;
	logic [32:0] ovprod_q;
	logic [DEN_W-1:0] den_q;
	logic [LEVEL_W-1:0] magfin_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic [29:0] postsq_q;
	logic [SUM_W-1:0] pre_sum_q;
	logic [SUM_W-1:0] post_sum_q;
	logic [LEVEL_W-1:0] peak_q;
	logic [LIMCNT_W-1:0] lim_cnt_q;
	logic [15:0] pre_rms_q;
	logic [SUM_W-1:0] sq_num_q;
	logic [ROOT_W-1:0] root_q;
	logic [ROOT_W+1:0] srem_q;
	logic [ROOT_CNT_W-1:0] sq_cnt_q;
	logic out_valid_q;
	out_item_t out_item_q;

	logic signed [26:0] prod_c;
	logic signed [31:0] csq;
	logic [18:0] gabs;
	logic [17:0] mag_c;
	logic [32:0] ovp;
	logic [DEN_W-1:0] den_c;
	logic [SUM_W:0] pre_add;
	logic [SUM_W:0] post_add;
	logic [LEVEL_W-1:0] capped;
	logic signed [SAMPLE_W-1:0] sample_c;
	logic [29:0] msq;
	logic [ROOT_W+3:0] sq_pair;
	logic [ROOT_W+3:0] sq_test;
	logic [ROOT_W+3:0] sq_diff;
	logic sq_fit;
	logic out_free;

	assign prod_c = clamped_q * $signed({1'b0, cfg.gain_q8});
	assign csq = clamped_q * clamped_q;
	assign gabs = prod_q[26] ? (~prod_q[26:8] + 1'b1) : prod_q[26:8];
	assign mag_c = gabs[17:0];
	assign ovp = over_q * range_q;
	assign den_c = DEN_W'(over_q) + DEN_W'(range_q);
	assign pre_add = {1'b0, pre_sum_q} + (SUM_W + 1)'(presq_q);
	assign post_add = {1'b0, post_sum_q} + (SUM_W + 1)'(postsq_q);
	assign capped = (mag_q > 18'(cfg.limit_ceiling)) ? cfg.limit_ceiling : mag_q[LEVEL_W-1:0];
	assign sample_c = neg_q ? -$signed({1'b0, capped}) : $signed({1'b0, capped});
	assign msq = magfin_q * magfin_q;
	assign sq_pair = {srem_q, sq_num_q[SUM_W-1 -: 2]};
	assign sq_test = {2'b00, root_q, 2'b01};
	assign sq_diff = sq_pair - sq_test;
	assign sq_fit = (sq_pair >= sq_test);
	assign out_free = !out_valid_q || !out_stall;

	assign pop = (state_q == ST_IDLE) && rd.valid;
	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

	always_comb begin
		div_req.start = (state_q == ST_LSTART) || (state_q == ST_PSTART)
			|| (state_q == ST_QSTART);
		div_req.long_mode = (state_q != ST_LSTART);
		div_req.divisor = (state_q == ST_LSTART) ? den_q : DEN_W'(count_q);
		case (state_q)
			ST_LSTART: div_req.dividend = SUM_W'(ovprod_q);
			ST_PSTART: div_req.dividend = pre_sum_q;
			default: div_req.dividend = post_sum_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			clamped_q <= '0;
			close_q <= 1'b0;
			count_q <= '0;
			prod_q <= '0;
			presq_q <= '0;
			neg_q <= 1'b0;
			mag_q <= '0;
			over_q <= '0;
			range_q <= '0;
			ovprod_q <= '0;
			den_q <= '0;
			magfin_q <= '0;
			sample_q <= '0;
			postsq_q <= '0;
			pre_sum_q <= '0;
			post_sum_q <= '0;
			peak_q <= '0;
			lim_cnt_q <= '0;
			pre_rms_q <= '0;
			sq_num_q <= '0;
			root_q <= '0;
			srem_q <= '0;
			sq_cnt_q <= '0;
			out_valid_q <= 1'b0;
			out_item_q <= '0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != ST_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (rd.valid) begin
						clamped_q <= rd.entry.clamped;
						close_q <= rd.entry.close;
						count_q <= rd.entry.count;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q <= prod_c;
					presq_q <= csq[30:0];
					state_q <= ST_LIM;
				end
				ST_LIM: begin
					pre_sum_q <= pre_add[SUM_W] ? SUM_MAX : pre_add[SUM_W-1:0];
					neg_q <= prod_q[26];
					mag_q <= mag_c;
					over_q <= mag_c - 18'(cfg.limit_knee);
					range_q <= (cfg.limit_ceiling > cfg.limit_knee)
						? (cfg.limit_ceiling - cfg.limit_knee) : '0;
					state_q <= (mag_c > 18'(cfg.limit_knee)) ? ST_OVR : ST_CAP;
				end
				ST_OVR: begin
					ovprod_q <= ovp;
					den_q <= den_c;
					state_q <= ST_LSTART;
				end
				ST_LSTART: begin
					state_q <= ST_DIVL;
				end
				ST_DIVL: begin
					if (div_rsp.done) begin
						mag_q <= 18'(cfg.limit_knee) + 18'(div_rsp.quotient[LEVEL_W-1:0]);
						if (lim_cnt_q != LIMCNT_MAX) begin
							lim_cnt_q <= lim_cnt_q + 1'b1;
						end
						state_q <= ST_CAP;
					end
				end
				ST_CAP: begin
					magfin_q <= capped;
					sample_q <= sample_c;
					state_q <= ST_POST;
				end
				ST_POST: begin
					postsq_q <= msq;
					if (magfin_q > peak_q) begin
						peak_q <= magfin_q;
					end
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					post_sum_q <= post_add[SUM_W] ? SUM_MAX : post_add[SUM_W-1:0];
					state_q <= close_q ? ST_PSTART : ST_EMIT;
				end
				ST_PSTART: begin
					state_q <= ST_DIVP;
				end
				ST_DIVP, ST_DIVQ: begin
					if (div_rsp.done) begin
						sq_num_q <= div_rsp.quotient;
						root_q <= '0;
						srem_q <= '0;
						sq_cnt_q <= ROOT_CNT_W'(ROOT_W);
						state_q <= (state_q == ST_DIVP) ? ST_SQP : ST_SQQ;
					end
				end
				ST_SQP, ST_SQQ: begin
					sq_num_q <= {sq_num_q[SUM_W-3:0], 2'b00};
					srem_q <= sq_fit ? sq_diff[ROOT_W+1:0] : sq_pair[ROOT_W+1:0];
					root_q <= {root_q[ROOT_W-2:0], sq_fit};
					sq_cnt_q <= sq_cnt_q - 1'b1;
					if (sq_cnt_q == ROOT_CNT_W'(1)) begin
						state_q <= (state_q == ST_SQP) ? ST_QSTART : ST_EMIT;
					end
				end
				ST_QSTART: begin
					pre_rms_q <= root_q[15:0];
					state_q <= ST_DIVQ;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_item_q.out_sample <= sample_q;
						out_item_q.frame_end <= close_q;
						if (close_q) begin
							out_item_q.pre_limit_rms <= pre_rms_q;
							out_item_q.post_limit_rms <= root_q[LEVEL_W-1:0];
							out_item_q.post_limit_peak <= peak_q;
							out_item_q.limited_samples <= lim_cnt_q;
							pre_sum_q <= '0;
							post_sum_q <= '0;
							peak_q <= '0;
							lim_cnt_q <= '0;
						end else begin
							out_item_q.pre_limit_rms <= '0;
							out_item_q.post_limit_rms <= '0;
							out_item_q.post_limit_peak <= '0;
							out_item_q.limited_samples <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/voice_dc_block_gain_soft_limit_unit.sv
// ----------------------------------------------------------------------------
// voice_dc_block_gain_soft_limit_unit
// DC-blocking high-pass, Q8 gain and rational soft limiter with frame stats.
// ----------------------------------------------------------------------------
//  channel | signals                           | accepted when
//  --------+-----------------------------------+---------------------------
//  in      | in_valid, in_stall, in_item       | in_valid && !in_stall
//  out     | out_valid, out_stall, out_item    | out_valid && !out_stall
//  cfg     | cfg_we, cfg_index, cfg_wdata      | cfg_we
//
//  Each item passes through the back sequencer, with a 16-step divide added
//  when it is limited, and two 40-step divides by the sample count and two
//  20-step square roots added when it closes a frame.
//  The front filters one item per cycle, while the queue is not full, into a two-item queue; in_stall is the
//  queue being full. Output holds in its register while out_stall is high.
//  Reset clears filter history, frame statistics and the registers to defaults.
// ----------------------------------------------------------------------------
module voice_dc_block_gain_soft_limit_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input vdc_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output vdc_pkg::out_item_t out_item,
	input logic cfg_we,
	input logic [vdc_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [vdc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import vdc_pkg::*;

	cfg_t cfg_q;
	q_wr_t q_wr;
	q_rd_t q_rd;
	logic q_full;
	logic q_pop;
	div_req_t div_req;
	div_rsp_t div_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_q8 <= GAIN_RST;
			cfg_q.limit_knee <= KNEE_RST;
			cfg_q.limit_ceiling <= CEIL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN: cfg_q.gain_q8 <= cfg_wdata[GAIN_W-1:0];
				REG_KNEE: cfg_q.limit_knee <= cfg_wdata[LEVEL_W-1:0];
				REG_CEIL: cfg_q.limit_ceiling <= cfg_wdata[LEVEL_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	vdc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.q_full(q_full),
		.q_wr(q_wr)
	);

	vdc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr(q_wr),
		.full(q_full),
		.rd(q_rd),
		.pop(q_pop)
	);

	vdc_divider u_divider (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	vdc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.rd(q_rd),
		.pop(q_pop),
		.div_req(div_req),
		.div_rsp(div_rsp),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	a_stats_zero_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.frame_end |-> out_item.pre_limit_rms == '0
			&& out_item.post_limit_rms == '0 && out_item.post_limit_peak == '0
			&& out_item.limited_samples == '0)
		else $error("frame stats nonzero on a mid-frame item");

	a_sample_symmetric: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.out_sample != 16'sh8000)
		else $error("limited sample outside symmetric range");

	a_rms_below_peak: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.frame_end |-> out_item.post_limit_rms <= out_item.post_limit_peak)
		else $error("post-limit rms exceeds frame peak");

endmodule

FILE: test/voice_dc_block_gain_soft_limit_unit_tb.sv
// ----------------------------------------------------------------------------
// voice_dc_block_gain_soft_limit_unit_tb
// Streams PCM samples in frames through the DC blocker, gain and soft limiter
// and checks every output item field by field against an in-bench predictor.
// Covers full-scale and alternating extremes, history clears, one-sample frames,
// frames closed at the length limit, and several gain/knee/ceiling settings,
// including a ceiling at or below the knee. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module voice_dc_block_gain_soft_limit_unit_tb;
	import vdc_pkg::*;

	typedef enum int {SHAPE_NOISE, SHAPE_LOUD, SHAPE_QUIET, SHAPE_OFFSET, SHAPE_SQUARE} shape_e;

	class limiter_frame_board;
		logic [GAIN_W-1:0] gain;
		logic [LEVEL_W-1:0] knee;
		logic [LEVEL_W-1:0] ceiling;
		longint prev_x;
		longint hist;
		longint unsigned pre_sum;
		longint unsigned post_sum;
		longint peak;
		int limited;
		int position;
		out_item_t awaited[$];
		int errors;
		int checked;
		int frames;
		int forced;
		int limited_seen;

		function new();
			gain = GAIN_RST;
			knee = KNEE_RST;
			ceiling = CEIL_RST;
			prev_x = 0;
			hist = 0;
			pre_sum = 0;
			post_sum = 0;
			peak = 0;
			limited = 0;
			position = 0;
			errors = 0;
			checked = 0;
			frames = 0;
			forced = 0;
			limited_seen = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_GAIN: gain = val[GAIN_W-1:0];
				REG_KNEE: knee = val[LEVEL_W-1:0];
				REG_CEIL: ceiling = val[LEVEL_W-1:0];
				default: ;
			endcase
		endfunction

		function longint unsigned root_floor(longint unsigned v);
			longint unsigned r;
			longint unsigned t;
			r = 0;
			for (int b = 20; b >= 0; b--) begin
				t = r | (64'd1 << b);
				if (t * t <= v)
					r = t;
			end
			return r;
		endfunction

		function void note_input(in_item_t it);
			longint x;
			longint y;
			longint c;
			longint g;
			longint mag;
			longint over;
			longint span;
			longint kn;
			longint cl;
			longint n;
			bit neg;
			bit close;
			out_item_t e;
			x = $signed(it.sample_in);
			kn = longint'(knee);
			cl = longint'(ceiling);
			if (it.clear_history) begin
				prev_x = 0;
				hist = 0;
			end
			y = x - prev_x + ((hist * 255) >>> 8);
			if (y > 33554431)
				y = 33554431;
			if (y < -33554432)
				y = -33554432;
			prev_x = x;
			hist = y;
			c = (y > 32767) ? 32767 : ((y < -32768) ? -32768 : y);
			pre_sum = pre_sum + longint'(c * c);
			if (pre_sum > SUM_MAX)
				pre_sum = SUM_MAX;
			g = (c * longint'(gain)) >>> 8;
			neg = g < 0;
			mag = neg ? -g : g;
			if (mag > kn) begin
				over = mag - kn;
				span = (cl > kn) ? cl - kn : 0;
				mag = kn + (over * span) / (over + span);
				if (limited < 1023)
					limited++;
				limited_seen++;
			end
			if (mag > cl)
				mag = cl;
			if (mag > peak)
				peak = mag;
			post_sum = post_sum + longint'(mag * mag);
			if (post_sum > SUM_MAX)
				post_sum = SUM_MAX;
			n = position + 1;
			close = it.frame_last || n >= FRAME_MAX;
			e = '0;
			e.out_sample = 16'(neg ? -mag : mag);
			if (close) begin
				e.frame_end = 1'b1;
				e.pre_limit_rms = 16'(root_floor(pre_sum / longint'(n)));
				e.post_limit_rms = 15'(root_floor(post_sum / longint'(n)));
				e.post_limit_peak = 15'(peak);
				e.limited_samples = 10'(limited);
				frames++;
				if (!it.frame_last)
					forced++;
				pre_sum = 0;
				post_sum = 0;
				peak = 0;
				limited = 0;
				position = 0;
			end else begin
				position = int'(n);
			end
			awaited.push_back(e);
		endfunction

		function void compare_field(string name, logic signed [63:0] want,
			logic signed [63:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t e;
			if (awaited.size() == 0) begin
				$error("out_sample: expected no item, got %0d", $signed(got.out_sample));
				errors++;
				return;
			end
			e = awaited.pop_front();
			checked++;
			compare_field("out_sample", $signed(e.out_sample), $signed(got.out_sample));
			compare_field("frame_end", e.frame_end, got.frame_end);
			compare_field("pre_limit_rms", e.pre_limit_rms, got.pre_limit_rms);
			compare_field("post_limit_rms", e.post_limit_rms, got.post_limit_rms);
			compare_field("post_limit_peak", e.post_limit_peak, got.post_limit_peak);
			compare_field("limited_samples", e.limited_samples, got.limited_samples);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	bit in_burst = 1'b0;
	bit out_burst = 1'b0;
	int sent_items = 0;
	limiter_frame_board board = new();

	voice_dc_block_gain_soft_limit_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(out_item);
	end

	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			hold = out_burst ? 0 : $urandom_range(0, 12);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_item(in_item_t it);
		int gap;
		gap = in_burst ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_input(it);
		sent_items++;
	endtask

	task automatic send_fields(logic signed [SAMPLE_W-1:0] s, bit last, bit clr);
		in_item_t it;
		it.sample_in = s;
		it.frame_last = last;
		it.clear_history = clr;
		send_item(it);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.awaited.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic apply_setting(int g, int k, int c);
		cfg_we <= 1'b1;
		cfg_index <= REG_GAIN;
		cfg_wdata <= CFG_DATA_W'(g);
		@(posedge clk);
		board.write_reg(REG_GAIN, CFG_DATA_W'(g));
		cfg_index <= REG_KNEE;
		cfg_wdata <= CFG_DATA_W'(k);
		@(posedge clk);
		board.write_reg(REG_KNEE, CFG_DATA_W'(k));
		cfg_index <= REG_CEIL;
		cfg_wdata <= CFG_DATA_W'(c);
		@(posedge clk);
		board.write_reg(REG_CEIL, CFG_DATA_W'(c));
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] next_sample(shape_e shape, int i,
		int offset, int period);
		int v;
		case (shape)
			SHAPE_LOUD: begin
				v = $urandom_range(20000, 32768);
				v = $urandom_range(0, 1) ? -v : ((v > 32767) ? 32767 : v);
			end
			SHAPE_QUIET: v = $urandom_range(0, 600) - 300;
			SHAPE_OFFSET: v = offset + $urandom_range(0, 2000) - 1000;
			SHAPE_SQUARE: v = ((i / period) % 2) ? -32768 : 32767;
			default: v = $urandom;
		endcase
		return SAMPLE_W'(v);
	endfunction

	task automatic run_frames(int quota, bit long_first);
		int goal;
		int len;
		int offset;
		int period;
		shape_e shape;
		in_item_t it;
		goal = sent_items + quota;
		while (sent_items < goal) begin
			if (long_first)
				len = 520;
			else if ($urandom_range(0, 39) == 0)
				len = $urandom_range(500, 620);
			else
				len = $urandom_range(1, 48);
			long_first = 1'b0;
			shape = shape_e'($urandom_range(0, 4));
			offset = $urandom_range(0, 40000) - 20000;
			period = $urandom_range(1, 8);
			for (int i = 0; i < len; i++) begin
				it.sample_in = next_sample(shape, i, offset, period);
				it.frame_last = (i == len - 1) || ($urandom_range(0, 63) == 0);
				it.clear_history = ($urandom_range(0, 31) == 0);
				send_item(it);
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_fields(32767, 1'b0, 1'b0);
		send_fields(-32768, 1'b0, 1'b0);
		send_fields(32767, 1'b0, 1'b0);
		send_fields(-32768, 1'b0, 1'b0);
		send_fields(0, 1'b0, 1'b0);
		send_fields(0, 1'b1, 1'b0);
		send_fields(-32768, 1'b1, 1'b1);
		send_fields(32767, 1'b1, 1'b1);
		send_fields(1, 1'b0, 1'b1);
		send_fields(-1, 1'b0, 1'b0);
		send_fields(16'sh5555, 1'b0, 1'b0);
		send_fields(-21846, 1'b0, 1'b0);
		send_fields(28673, 1'b0, 1'b1);
		send_fields(-28673, 1'b0, 1'b1);
		send_fields(0, 1'b1, 1'b1);
		drain();

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: apply_setting(1023, 0, 32767);
				1: apply_setting(0, 32766, 32767);
				2: apply_setting(512, 8000, 12000);
				3: apply_setting(1023, 32766, 1);
				4: apply_setting(768, 20000, 20000);
				7: apply_setting(300, 1, 32767);
				default: apply_setting($urandom_range(0, 1023), $urandom_range(0, 32766),
					$urandom_range(1, 32767));
			endcase
			in_burst = (p % 3 == 1);
			out_burst = (p % 3 == 2);
			run_frames(150, p == 2);
			drain();
		end

		repeat (200) @(posedge clk);
		$display("Sent %0d sample items and checked %0d output items over 9 register settings.",
			sent_items, board.checked);
		$display("Closed %0d frames (%0d at the length limit); %0d samples went above the knee.",
			board.frames, board.forced, board.limited_seen);
		if (board.errors == 0 && board.awaited.size() == 0) begin
			$display("voice_dc_block_gain_soft_limit_unit verification clean");
		end else begin
			$display("voice_dc_block_gain_soft_limit_unit verification failed");
		end
		$finish;
	end

	initial begin
		#200_000_000;
		$display("voice_dc_block_gain_soft_limit_unit verification failed");
		$finish;
	end

endmodule
